// ===== src/qbd_pkg.sv =====
// Shared types and constants for the quant block dequantizer.
package qbd_pkg;

  typedef enum logic [2:0] {
    FMT_Q4_0 = 3'd0,
    FMT_Q4_1 = 3'd1,
    FMT_Q4_2 = 3'd2,
    FMT_Q4_3 = 3'd3,
    FMT_Q8_0 = 3'd4
  } fmt_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF   = 32'h7F80_0000;

  localparam logic [4:0] BYTES_Q4   = 5'd16;
  localparam logic [4:0] BYTES_Q4H  = 5'd8;
  localparam logic [4:0] BYTES_Q8   = 5'd31 + 5'd1;  // 32 wraps to 0 in 5 bits
  localparam logic [3:0] NIB_BIAS   = 4'd8;

  // One accepted quant byte with its block context.
  typedef struct packed {
    logic [7:0]  qbyte;
    logic        pair;    // two nibble values
    logic        bias;    // subtract 8 from each nibble
    logic [31:0] scale;
    logic [31:0] addend;
    logic        last;
  } entry_t;

  // One multiply-add for the arithmetic pipeline.
  typedef struct packed {
    logic signed [7:0] mul;
    logic [31:0]       scale;
    logic [31:0]       addend;
    logic              last;
  } op_t;

endpackage

// ===== src/qbd_front.sv =====
// Front end: format register, block position, scale/min latch, beat classification.
module qbd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [2:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       scale_bits,
  input  logic [31:0]       min_bits,
  input  logic [7:0]        quant_byte,
  output logic              push,
  output qbd_pkg::entry_t   push_entry,
  input  logic              push_ready
);

  logic [2:0]  fmt;
  logic [4:0]  byte_pos;
  logic [31:0] held_scale;
  logic [31:0] held_min;

  logic        fmt_ok;
  logic        half_fmt;
  logic        use_min;
  logic [4:0]  last_pos;
  logic [4:0]  pos_eff;
  logic        start;
  logic        accept;
  logic [31:0] scale_l;
  logic [31:0] min_l;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] res;
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic [3:0]  k;
    logic [9:0]  frs;
    ex  = h[14:10];
    fr  = h[9:0];
    k   = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (fr[i]) k = 4'(10 - i);
    end
    frs = fr << k;
    if (ex == 5'd0) begin
      if (fr == 10'd0) res = {h[15], 31'd0};
      else res = {h[15], 8'(8'd113 - {4'd0, k}), frs, 13'd0};
    end else if (ex == 5'h1f) begin
      res = {h[15], 8'hff, fr, 13'd0};
    end else begin
      res = {h[15], 8'({3'd0, ex} + 8'd112), fr, 13'd0};
    end
    return res;
  endfunction

  function automatic logic [4:0] BYTES_LAST(input logic [4:0] n);
    return n - 5'd1;
  endfunction

  always_comb begin
    fmt_ok   = 1'b1;
    half_fmt = 1'b0;
    use_min  = 1'b0;
    last_pos = BYTES_LAST(qbd_pkg::BYTES_Q4);
    unique case (fmt)
      qbd_pkg::FMT_Q4_0: ;
      qbd_pkg::FMT_Q4_1: use_min = 1'b1;
      qbd_pkg::FMT_Q4_2: begin
        half_fmt = 1'b1;
        last_pos = BYTES_LAST(qbd_pkg::BYTES_Q4H);
      end
      qbd_pkg::FMT_Q4_3: begin
        half_fmt = 1'b1;
        use_min  = 1'b1;
        last_pos = BYTES_LAST(qbd_pkg::BYTES_Q4H);
      end
      qbd_pkg::FMT_Q8_0: last_pos = BYTES_LAST(qbd_pkg::BYTES_Q8);
      default: fmt_ok = 1'b0;
    endcase
  end

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign pos_eff  = (byte_pos > last_pos) ? 5'd0 : byte_pos;
  assign start    = (pos_eff == 5'd0);

  always_comb begin
    if (start) begin
      scale_l = half_fmt ? half_to_single(scale_bits[15:0]) : scale_bits;
      min_l   = half_fmt ? half_to_single(min_bits[15:0]) : min_bits;
    end else begin
      scale_l = held_scale;
      min_l   = held_min;
    end
  end

  assign push                = accept && fmt_ok;
  assign push_entry.qbyte    = quant_byte;
  assign push_entry.pair     = (fmt != qbd_pkg::FMT_Q8_0);
  assign push_entry.bias     = (fmt == qbd_pkg::FMT_Q4_0) || (fmt == qbd_pkg::FMT_Q4_2);
  assign push_entry.scale    = scale_l;
  assign push_entry.addend   = use_min ? min_l : qbd_pkg::SIGN_BIT;
  assign push_entry.last     = (pos_eff == last_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt        <= 3'd0;
      byte_pos   <= 5'd0;
      held_scale <= 32'd0;
      held_min   <= 32'd0;
    end else if (cfg_wen) begin
      fmt      <= cfg_wdata;
      byte_pos <= 5'd0;
    end else if (push) begin
      held_scale <= scale_l;
      held_min   <= min_l;
      byte_pos   <= (pos_eff == last_pos) ? 5'd0 : pos_eff + 5'd1;
    end
  end

endmodule

// ===== src/qbd_queue.sv =====
// Short queue of classified beats between front and back.
module qbd_queue #(
  parameter int unsigned DEPTH = qbd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qbd_pkg::entry_t push_entry,
  output logic            push_ready,
  output logic            head_valid,
  output qbd_pkg::entry_t head,
  input  logic            pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  qbd_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;

  assign push_ready = (count != CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && push_ready) mem[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && push_ready) wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      if (pop && head_valid) rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      unique case ({push && push_ready, pop && head_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/qbd_back.sv =====
// Back end issue: splits a queued beat into one or two multiply-add ops.
module qbd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  qbd_pkg::entry_t head,
  output logic            pop,
  output logic            op_valid,
  output qbd_pkg::op_t    op,
  input  logic            op_ready
);

  logic       upper;   // second nibble of the current beat
  logic [3:0] nib;
  logic       fire;
  logic       done;

  assign nib      = upper ? head.qbyte[7:4] : head.qbyte[3:0];
  assign op_valid = head_valid;
  assign fire     = op_valid && op_ready;
  assign done     = !head.pair || upper;
  assign pop      = fire && done;

  always_comb begin
    if (!head.pair) op.mul = $signed(head.qbyte);
    else if (head.bias) op.mul = $signed({4'd0, nib}) - $signed({4'd0, qbd_pkg::NIB_BIAS});
    else op.mul = $signed({4'd0, nib});
  end
  assign op.scale  = head.scale;
  assign op.addend = head.addend;
  assign op.last   = head.last && done;

  always_ff @(posedge clk) begin
    if (rst) upper <= 1'b0;
    else if (fire && head.pair) upper <= !upper;
  end

endmodule

// ===== src/qbd_fma.sv =====
// Pipelined fused multiply-add q*scale+addend with one RNE rounding to single.
module qbd_fma (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  qbd_pkg::op_t op,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  value_bits,
  output logic         last_of_block
);

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  function automatic logic [6:0] lzc66(input logic [65:0] v);
    logic [6:0] n;
    n = 7'd66;
    for (int i = 0; i < 66; i++) begin
      if (v[i]) n = 7'(65 - i);
    end
    return n;
  endfunction

  typedef struct packed {
    logic nan;
    logic inf;
    logic inf_sign;
    logic zero;      // both terms zero
    logic zero_sign;
    logic last;
  } flags_t;

  logic adv;
  logic va, vb, vc, vd, ve;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage A: operand register
  qbd_pkg::op_t a_op;

  // stage B: product and unpack
  logic        sa, sd, sm, sp;
  logic [7:0]  ed, em, amag;
  logic [22:0] fd, fm;
  logic        d_nan, d_inf, m_nan, m_inf;
  flags_t      b_fl_n;
  logic [31:0] b_p;
  logic        b_sp, b_sm;
  logic [7:0]  b_ed, b_em;
  logic [23:0] b_mm;
  flags_t      b_fl;

  assign sa   = a_op.mul[7];
  assign amag = sa ? 8'(-a_op.mul) : a_op.mul;
  assign sd   = a_op.scale[31];
  assign ed   = a_op.scale[30:23];
  assign fd   = a_op.scale[22:0];
  assign sm   = a_op.addend[31];
  assign em   = a_op.addend[30:23];
  assign fm   = a_op.addend[22:0];
  assign sp   = sa ^ sd;
  assign d_nan = (ed == 8'hff) && (fd != 23'd0);
  assign d_inf = (ed == 8'hff) && (fd == 23'd0);
  assign m_nan = (em == 8'hff) && (fm != 23'd0);
  assign m_inf = (em == 8'hff) && (fm == 23'd0);

  always_comb begin
    b_fl_n.nan = d_nan || m_nan || (d_inf && amag == 8'd0)
               || (d_inf && amag != 8'd0 && m_inf && sp != sm);
    b_fl_n.inf = (d_inf && amag != 8'd0) || m_inf;
    b_fl_n.inf_sign  = (d_inf && amag != 8'd0) ? sp : sm;
    b_fl_n.zero      = 1'b0;
    b_fl_n.zero_sign = 1'b0;
    b_fl_n.last      = a_op.last;
  end

  // stage C: normalize both terms, order by magnitude
  logic [5:0]        lzp, lzm;
  logic [31:0]       sigp, sigm, m32;
  logic signed [9:0] ep, em_s;
  logic              pz, mz, p_big;
  logic signed [9:0] diff;
  logic [31:0]       c_sigx, c_sigy;
  logic signed [9:0] c_ex;
  logic              c_sx, c_sub;
  logic [5:0]        c_diff;
  flags_t            c_fl;

  assign m32  = {b_mm, 8'd0};
  assign lzp  = lzc32(b_p);
  assign lzm  = lzc32(m32);
  assign sigp = b_p << lzp;
  assign sigm = m32 << lzm;
  assign ep   = $signed({2'd0, b_ed}) - $signed({4'd0, lzp});
  assign em_s = $signed({2'd0, b_em}) - 10'sd8 - $signed({4'd0, lzm});
  assign pz   = (b_p == 32'd0);
  assign mz   = (b_mm == 24'd0);
  assign p_big = mz || (!pz && ((ep > em_s) || (ep == em_s && sigp >= sigm)));
  assign diff = p_big ? (ep - em_s) : (em_s - ep);

  // stage D: align and add
  logic [64:0] xf, yf, yshift;
  logic [65:0] d_sum;
  logic signed [9:0] d_ex;
  logic        d_sx;
  flags_t      d_fl;

  assign xf     = {c_sigx, 33'd0};
  assign yshift = {c_sigy, 33'd0} >> c_diff;
  assign yf     = (c_diff == 6'd34) ? {64'd0, c_sigy != 32'd0} : yshift;

  // stage E: normalize sum
  logic [6:0]         lz;
  logic [65:0]        e_n;
  logic signed [10:0] e_er;
  logic               e_sx, e_szero;
  flags_t             e_fl;

  assign lz = lzc66(d_sum);

  // stage F: subnormal shift, round, pack
  logic signed [10:0] rs_t;
  logic [6:0]         rs;
  logic [131:0]       wide;
  logic [23:0]        m24;
  logic               rbit, sticky, rnd;
  logic [7:0]         efield;
  logic [31:0]        packed_v;
  logic [31:0]        result;

  always_comb begin
    rs_t = 11'sd1 - e_er;
    if (e_er >= 11'sd1) rs = 7'd0;
    else if (rs_t > 11'sd66) rs = 7'd66;
    else rs = rs_t[6:0];
    wide     = {e_n, 66'd0} >> rs;
    m24      = wide[131:108];
    rbit     = wide[107];
    sticky   = |wide[106:0];
    rnd      = rbit && (sticky || m24[0]);
    efield   = (e_er >= 11'sd1) ? 8'(e_er[7:0] - 8'd1) : 8'd0;
    packed_v = {1'b0, efield, 23'd0} + {8'd0, m24} + {31'd0, rnd};
    if (e_fl.nan) result = qbd_pkg::CANON_NAN;
    else if (e_fl.inf) result = {e_fl.inf_sign, qbd_pkg::POS_INF[30:0]};
    else if (e_fl.zero) result = {e_fl.zero_sign, 31'd0};
    else if (e_szero) result = 32'd0;
    else if (e_er > 11'sd254) result = {e_sx, qbd_pkg::POS_INF[30:0]};
    else result = {e_sx, packed_v[30:0]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op <= op;

      b_p  <= {24'd0, amag} * {8'd0, (ed != 8'd0), fd};
      b_sp <= sp;
      b_sm <= sm;
      b_ed <= (ed == 8'd0) ? 8'd1 : ed;
      b_em <= (em == 8'd0) ? 8'd1 : em;
      b_mm <= {(em != 8'd0), fm};
      b_fl <= b_fl_n;

      c_sigx <= p_big ? sigp : sigm;
      c_sigy <= (pz || mz) ? 32'd0 : (p_big ? sigm : sigp);
      c_ex   <= p_big ? ep : em_s;
      c_sx   <= p_big ? b_sp : b_sm;
      c_sub  <= b_sp != b_sm;
      c_diff <= (diff > 10'sd33) ? 6'd34 : diff[5:0];
      c_fl   <= '{nan: b_fl.nan, inf: b_fl.inf, inf_sign: b_fl.inf_sign,
                  zero: pz && mz, zero_sign: b_sp && b_sm, last: b_fl.last};

      d_sum <= c_sub ? ({1'b0, xf} - {1'b0, yf}) : ({1'b0, xf} + {1'b0, yf});
      d_ex  <= c_ex;
      d_sx  <= c_sx;
      d_fl  <= c_fl;

      e_n     <= d_sum << lz;
      e_er    <= $signed({d_ex[9], d_ex}) + 11'sd9 - $signed({4'd0, lz});
      e_sx    <= d_sx;
      e_szero <= (d_sum == 66'd0);
      e_fl    <= d_fl;

      value_bits    <= result;
      last_of_block <= e_fl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      out_valid <= ve;
    end
  end

endmodule

// ===== src/quant_block_dequantizer.sv =====
// Top level of the quant block dequantizer.
// Takes one quant byte per beat and returns IEEE single values, low nibble first for the
// nibble formats and one value per byte for q8_0; beats under an unused format code are
// accepted and dropped. The input side accepts a beat every cycle while the beat queue
// has room; results leave at one per cycle on the output port while out_ready is high,
// a nibble byte giving two values and a q8_0 byte one; this port sets the pace. Values
// pass the six-stage fused multiply-add pipeline. A format write restarts the block.
module quant_block_dequantizer #(
  parameter int unsigned QUEUE_DEPTH = qbd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] scale_bits,
  input  logic [31:0] min_bits,
  input  logic [7:0]  quant_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value_bits,
  output logic        last_of_block
);

  logic            push, push_ready;
  qbd_pkg::entry_t push_entry;
  logic            head_valid, pop;
  qbd_pkg::entry_t head;
  logic            op_valid, op_ready;
  qbd_pkg::op_t    op;

  qbd_front u_front (
    .clk, .rst, .cfg_wen, .cfg_wdata, .in_valid, .in_ready,
    .scale_bits, .min_bits, .quant_byte,
    .push, .push_entry, .push_ready
  );

  qbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .push_entry, .push_ready, .head_valid, .head, .pop
  );

  qbd_back u_back (
    .clk, .rst, .head_valid, .head, .pop, .op_valid, .op, .op_ready
  );

  qbd_fma u_fma (
    .clk, .rst, .in_valid(op_valid), .in_ready(op_ready), .op,
    .out_valid, .out_ready, .value_bits, .last_of_block
  );

  // a stalled result holds the whole arithmetic pipeline
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !op_ready)
    else $error("fma accepted an op while its output was stalled");

  // NaN results leave only in canonical form
  a_canon_nan: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_bits[30:23] == 8'hff && value_bits[22:0] != 23'd0
    |-> value_bits == qbd_pkg::CANON_NAN)
    else $error("non-canonical NaN on result");

  // front is only held off by a full queue
  a_ready_queue: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> head_valid)
    else $error("input stalled with empty queue");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for quant_block_dequantizer.
module tb;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } deq_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] scale_bits = '0;
  logic [31:0] min_bits = '0;
  logic [7:0]  quant_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value_bits;
  logic        last_of_block;

  quant_block_dequantizer u_top (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .scale_bits(scale_bits),
    .min_bits(min_bits), .quant_byte(quant_byte), .out_valid(out_valid),
    .out_ready(out_ready), .value_bits(value_bits), .last_of_block(last_of_block)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [2:0]  cur_fmt;
  logic [31:0] blk_scale, blk_min;
  int unsigned blk_pos;
  deq_result_t pending_values[$];

  int errors = 0;
  int beats_sent = 0;
  int values_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;

  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [31:0] s;
    logic [4:0]  ex;
    logic [9:0]  fr;
    int          e32;
    s = {h[15], 31'b0};
    ex = h[14:10];
    fr = h[9:0];
    if (ex == 0) begin
      if (fr == 0) return s;
      e32 = 113;
      while (!fr[9]) begin
        fr = fr << 1;
        e32--;
      end
      fr = fr << 1;  // drop the now-implicit leading one
      e32--;
      return s | (32'(e32) << 23) | ({22'b0, fr} << 13);
    end
    if (ex == 5'h1f) return s | qbd_pkg::POS_INF | ({22'b0, fr} << 13);
    return s | (32'(ex + 112) << 23) | ({22'b0, fr} << 13);
  endfunction

  // q*scale + addend, exact sum then one round-to-nearest-even
  function automatic logic [31:0] fma_round(int q, logic [31:0] d, logic [31:0] m);
    logic signed [319:0] acc, term;
    logic [319:0] mag, rem, half;
    logic [63:0]  mant;
    int md, mm, ed, em, emin, lead, qe, sh, biased;
    logic sd, sm, ps, neg;
    sd = d[31];
    sm = m[31];
    ps = sd ^ (q < 0);
    if ((d[30:23] == 8'hff && d[22:0] != 0) || (m[30:23] == 8'hff && m[22:0] != 0))
      return qbd_pkg::CANON_NAN;
    if (d[30:23] == 8'hff) begin
      if (q == 0) return qbd_pkg::CANON_NAN;
      if (m[30:23] == 8'hff && sm != ps) return qbd_pkg::CANON_NAN;
      return {ps, qbd_pkg::POS_INF[30:0]};
    end
    if (m[30:23] == 8'hff) return m;
    md = (d[30:23] == 0) ? int'(d[22:0]) : int'({1'b1, d[22:0]});
    ed = (d[30:23] == 0) ? -149 : int'(d[30:23]) - 150;
    mm = (m[30:23] == 0) ? int'(m[22:0]) : int'({1'b1, m[22:0]});
    em = (m[30:23] == 0) ? -149 : int'(m[30:23]) - 150;
    emin = (ed < em) ? ed : em;
    acc = 320'(signed'(longint'(q) * longint'(md)));
    if (sd) acc = -acc;
    acc = acc <<< (ed - emin);
    term = 320'(signed'(longint'(mm)));
    term = term <<< (em - emin);
    acc = sm ? acc - term : acc + term;
    if (acc == 0) begin
      if ((q == 0 || md == 0) && mm == 0) return {ps & sm, 31'b0};
      return 32'b0;
    end
    neg = acc[319];
    mag = neg ? -acc : acc;
    lead = 0;
    for (int i = 0; i < 320; i++) if (mag[i]) lead = i;
    qe = lead + emin - 23;
    if (qe < -149) qe = -149;
    sh = qe - emin;
    if (sh <= 0) begin
      mant = 64'(mag << (-sh));
    end else begin
      mant = 64'(mag >> sh);
      rem = mag & ((320'b1 << sh) - 1);
      half = 320'b1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant++;
    end
    if (mant[24]) begin
      mant = mant >> 1;
      qe++;
    end
    if (!mant[23]) return {neg, 31'(mant)};  // subnormal
    biased = qe + 150;
    if (biased >= 255) return {neg, qbd_pkg::POS_INF[30:0]};
    return {neg, 8'(biased), mant[22:0]};
  endfunction

  function automatic void predict_beat(logic [31:0] s, logic [31:0] mn, logic [7:0] b);
    int unsigned blk_len;
    int          bias;
    logic        last;
    logic [31:0] add;
    if (cur_fmt > qbd_pkg::FMT_Q8_0) return;
    blk_len = (cur_fmt == qbd_pkg::FMT_Q8_0) ? 32 : (cur_fmt >= qbd_pkg::FMT_Q4_2 ? 8 : 16);
    if (blk_pos >= blk_len) blk_pos = 0;
    if (blk_pos == 0) begin
      if (cur_fmt == qbd_pkg::FMT_Q4_2 || cur_fmt == qbd_pkg::FMT_Q4_3) begin
        blk_scale = widen_half(s[15:0]);
        blk_min = widen_half(mn[15:0]);
      end else begin
        blk_scale = s;
        blk_min = mn;
      end
    end
    last = (blk_pos == blk_len - 1);
    blk_pos = last ? 0 : blk_pos + 1;
    if (cur_fmt == qbd_pkg::FMT_Q8_0) begin
      pending_values.push_back('{fma_round(int'($signed(b)), blk_scale, qbd_pkg::SIGN_BIT),
                                 last});
      return;
    end
    add = (cur_fmt == qbd_pkg::FMT_Q4_1 || cur_fmt == qbd_pkg::FMT_Q4_3) ? blk_min
                                                                          : qbd_pkg::SIGN_BIT;
    bias = (cur_fmt == qbd_pkg::FMT_Q4_0 || cur_fmt == qbd_pkg::FMT_Q4_2) ? 8 : 0;
    pending_values.push_back('{fma_round(int'(b[3:0]) - bias, blk_scale, add), 1'b0});
    pending_values.push_back('{fma_round(int'(b[7:4]) - bias, blk_scale, add), last});
  endfunction

  // caller is at a falling edge; returns at a falling edge
  task automatic send_beat(logic [31:0] s, logic [31:0] mn, logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    scale_bits = s;
    min_bits = mn;
    quant_byte = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_beat(s, mn, b);
    beats_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);  // idle margin; bytes under unused format codes never enter the queue
  endtask

  task automatic write_format(logic [2:0] f);
    drain();
    cfg_wdata = f;
    cfg_wen = 1'b1;
    @(negedge clk);
    cfg_wen = 1'b0;
    cur_fmt = f;
    blk_pos = 0;
  endtask

  function automatic logic [31:0] pick_scale(bit half_fmt);
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: return r;
      1: return half_fmt ? {r[31:16], r[15], 5'h1f, r[9:0]} : {r[31], 8'hff, r[22:0]};
      2: return half_fmt ? {r[31:16], r[15], 5'h00, r[9:0]} : {r[31], 8'h00, r[22:0]};
      3: return half_fmt ? {r[31:16], r[15], 5'h1e, r[9:0]} : {r[31], 8'hfe, r[22:0]};
      default:
        return half_fmt ? {r[31:16], r[15], 5'(12 + r[2:0]), r[9:0]}
                        : {r[31], 8'(120 + r[3:0]), r[22:0]};
    endcase
  endfunction

  task automatic send_random_block(int n);
    bit hf;
    hf = (cur_fmt == qbd_pkg::FMT_Q4_2 || cur_fmt == qbd_pkg::FMT_Q4_3);
    for (int i = 0; i < n; i++) send_beat(pick_scale(hf), pick_scale(hf), 8'($urandom()));
  endtask

  task automatic test_directed;
    logic [31:0] mins[4] = '{32'h0000_0000, 32'h8000_0000, 32'hc000_0000, 32'h7f7f_ffff};
    write_format(qbd_pkg::FMT_Q4_0);
    send_beat(32'h3f80_0000, 32'h0, 8'h80);  // -8 and +0 outputs
    send_beat(32'h0, 32'h0, 8'h0f);
    send_beat(32'h7f80_0000, 32'h0, 8'hff);  // inf scale into a running block: held value used
    write_format(qbd_pkg::FMT_Q4_0);
    send_beat(32'h7f80_0000, 32'h0, 8'h08);  // inf * 0 gives NaN
    write_format(qbd_pkg::FMT_Q8_0);
    send_beat(32'h7f7f_ffff, 32'h0, 8'h7f);  // overflow to inf
    send_beat(32'h0, 32'h0, 8'h80);
    send_beat(32'h0, 32'h0, 8'h00);
    write_format(qbd_pkg::FMT_Q4_1);
    foreach (mins[i]) begin
      write_format(qbd_pkg::FMT_Q4_1);
      send_beat(32'h7f7f_ffff, mins[i], 8'hf0);
    end
    write_format(qbd_pkg::FMT_Q4_2);
    send_beat(32'hffff_0001, 32'h0, 8'h1f);  // fp16 subnormal, high half ignored
    write_format(qbd_pkg::FMT_Q4_3);
    send_beat(32'h0000_7c00, 32'h0000_fc00, 8'hf1);  // inf + -inf
    write_format(qbd_pkg::FMT_Q4_3);
    send_beat(32'h0000_7e00, 32'h0000_3c00, 8'h55);
    write_format(3'd5);
    send_beat(32'h3f80_0000, 32'h0, 8'h12);
    write_format(3'd7);
    send_beat(32'h3f80_0000, 32'h0, 8'h34);
  endtask

  task automatic test_random_formats(int n_beats);
    int left;
    left = n_beats;
    while (left > 0) begin
      write_format(3'($urandom_range(4)));
      if ($urandom_range(15) == 0) write_format(3'($urandom_range(7, 5)));
      for (int k = $urandom_range(3, 1); k > 0 && left > 0; k--) begin
        int n;
        n = (cur_fmt == qbd_pkg::FMT_Q8_0) ? 32 : (cur_fmt >= qbd_pkg::FMT_Q4_2 ? 8 : 16);
        if ($urandom_range(4) == 0) n = $urandom_range(n, 1);  // cut-short block
        send_random_block(n);
        left -= n;
      end
    end
  endtask

  task automatic test_pause_until_empty;
    write_format(qbd_pkg::FMT_Q4_1);
    send_random_block(5);
    while (pending_values.size() != 0) @(negedge clk);
    send_random_block(11);
  endtask

  always @(negedge clk) out_ready = ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    deq_result_t want;
    cycles++;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      values_seen++;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected value %h last %b", $time, value_bits, last_of_block);
        errors++;
      end else begin
        want = pending_values.pop_front();
        if (value_bits !== want.value) begin
          $display("%0t: value_bits expected %h actual %h", $time, want.value, value_bits);
          errors++;
        end
        if (last_of_block !== want.last) begin
          $display("%0t: last_of_block expected %b actual %b", $time, want.last,
                   last_of_block);
          errors++;
        end
      end
    end
  end

  initial begin
    cur_fmt = qbd_pkg::FMT_Q4_0;
    blk_scale = '0;
    blk_min = '0;
    blk_pos = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    test_directed();
    send_idle_pct = 19;
    recv_idle_pct = 74;
    test_random_formats(130);
    test_pause_until_empty();
    send_idle_pct = 74;
    recv_idle_pct = 19;
    test_random_formats(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_formats(130);
    drain();
    repeat (20) @(negedge clk);
    if (pending_values.size() != 0) errors++;
    $display("covered all five formats plus unused codes: %0d beats, %0d values checked",
             beats_sent, values_seen);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/qbd_pkg.sv
src/qbd_front.sv
src/qbd_queue.sv
src/qbd_back.sv
src/qbd_fma.sv
src/quant_block_dequantizer.sv
test/tb.sv
